@@ rtl/docq_pkg.sv @@
// Shared types and constants of the drop-oldest chunk queue.
`default_nettype none

package docq_pkg;

  localparam int BYTES_W = 10;

  // Input word kinds.
  typedef enum logic [2:0] {
    KIND_PUSH    = 3'd0,
    KIND_POP     = 3'd1,
    KIND_DISCARD = 3'd2,
    KIND_START   = 3'd3,
    KIND_STOP    = 3'd4
  } kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NOT_READY = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // an input word is taken this cycle
    logic load_single;  // load the single result of the accepted word
    logic pop_word;     // load the next word of the chunk being popped
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic nonempty;     // at least one chunk is queued
    logic last_word;    // the pop word now offered is the final one
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/docq_ctrl.sv @@
// Controller state machine of the drop-oldest chunk queue.
`default_nettype none

module docq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_kind,
  output logic                  out_valid,
  input  logic                  out_stall,
  output docq_pkg::ctrl_cmd_t   cmd,
  input  docq_pkg::dp_status_t  st
);
  import docq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   pop_start;

  // The output register can take a new word when it is empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;
  assign pop_start = (in_kind == KIND_POP) && st.nonempty;

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = out_valid_r && out_stall;
    cmd.accept      = 1'b0;
    cmd.load_single = 1'b0;
    cmd.pop_word    = 1'b0;
    in_stall        = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = !out_free;
        if (in_valid && out_free) begin
          cmd.accept = 1'b1;
          if (pop_start) begin
            state_nxt = S_POP;
          end else begin
            cmd.load_single = 1'b1;
            out_valid_nxt   = 1'b1;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          cmd.pop_word  = 1'b1;
          out_valid_nxt = 1'b1;
          if (st.last_word) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/docq_dp.sv @@
// Datapath of the drop-oldest chunk queue: slot memories, pointers, counters, output register.
`default_nettype none

module docq_dp #(
  parameter int QUEUE_DEPTH = 8,
  parameter int CHUNK_WORDS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  docq_pkg::ctrl_cmd_t                 cmd,
  output docq_pkg::dp_status_t                st,
  input  logic [2:0]                          in_kind,
  input  logic [63:0]                         in_payload_word,
  input  logic                                in_word_last,
  input  logic [docq_pkg::BYTES_W-1:0]        in_chunk_bytes,
  input  logic [63:0]                         in_timestamp_ns,
  input  logic [31:0]                         in_upstream_dropped,
  output logic [1:0]                          out_status,
  output logic [63:0]                         out_payload,
  output logic                                out_last,
  output logic [docq_pkg::BYTES_W-1:0]        out_bytes,
  output logic [63:0]                         out_timestamp,
  output logic [31:0]                         out_dropped,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    out_queue_count,
  output logic [31:0]                         out_chunks_dropped,
  output logic                                out_stop_flag
);
  import docq_pkg::*;

  // One spare slot holds the chunk being staged, so a full queue never
  // overwrites a live chunk while words arrive.
  localparam int SLOTS = QUEUE_DEPTH + 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int WW    = (CHUNK_WORDS > 1) ? $clog2(CHUNK_WORDS) : 1;
  localparam int CNTW  = $clog2(CHUNK_WORDS + 1);
  localparam int MEMD  = SLOTS << WW;

  localparam logic [SW-1:0]      LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [FW-1:0]      FULL      = FW'(QUEUE_DEPTH);
  localparam logic [CNTW-1:0]    CW_C      = CNTW'(CHUNK_WORDS);
  localparam logic [BYTES_W-1:0] MAX_B     = BYTES_W'(CHUNK_WORDS * 8);

  function automatic logic [SW-1:0] inc_slot(input logic [SW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SW'(1);
  endfunction

  // Keeps the low rem bytes of a word; rem of zero keeps all eight.
  function automatic logic [63:0] byte_mask(input logic [2:0] rem);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if ((rem == 3'd0) || (3'(b) < rem)) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // Memories.
  logic [63:0]         pay_mem   [0:MEMD-1];
  logic [BYTES_W-1:0]  bytes_mem [0:SLOTS-1];
  logic [63:0]         time_mem  [0:SLOTS-1];
  logic [31:0]         drops_mem [0:SLOTS-1];
  logic [CNTW-1:0]     words_mem [0:SLOTS-1];

  // State.
  logic [SW-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [FW-1:0]   fill_r, fill_nxt;
  logic [31:0]     drop_r, drop_nxt;
  logic            worker_r, worker_nxt, stop_r, stop_nxt;
  logic [CNTW-1:0] stg_cnt_r, stg_cnt_nxt;
  logic            stg_ovf_r, stg_ovf_nxt;
  logic [SW-1:0]   pop_slot_r, pop_slot_nxt;
  logic [WW-1:0]   pop_idx_r, pop_idx_nxt;

  // Registered reads of the head chunk.
  logic [BYTES_W-1:0] m_bytes_r;
  logic [63:0]        m_time_r;
  logic [31:0]        m_drops_r;
  logic [CNTW-1:0]    m_words_r;
  logic [63:0]        rd_word_r;

  // Output register.
  logic [1:0]         out_status_r;
  logic [63:0]        out_payload_r;
  logic               out_last_r;
  logic [BYTES_W-1:0] out_bytes_r;
  logic [63:0]        out_timestamp_r;
  logic [31:0]        out_dropped_r;
  logic [FW-1:0]      out_queue_count_r;
  logic [31:0]        out_chunks_dropped_r;
  logic               out_stop_flag_r;

  logic               is_push, is_pop;
  logic               stg_room, push_wr, pop_start, commit_ok;
  logic               bad, not_ready, full;
  logic [CNTW-1:0]    words_commit;
  logic [1:0]         sta;
  logic               rd_en;
  logic [SW+WW-1:0]   rd_addr;
  logic [10:0]        nwords;
  logic               pop_last, word_present;
  logic [63:0]        pop_payload;

  assign is_push   = (in_kind == KIND_PUSH);
  assign is_pop    = (in_kind == KIND_POP);
  assign stg_room  = stg_cnt_r < CW_C;
  assign push_wr   = cmd.accept && is_push && stg_room;
  assign pop_start = cmd.accept && is_pop && (fill_r != '0);
  assign full      = (fill_r == FULL);

  assign words_commit = stg_room ? stg_cnt_r + CNTW'(1) : stg_cnt_r;
  assign bad          = (in_chunk_bytes == '0) || (in_chunk_bytes > MAX_B)
                        || stg_ovf_r || !stg_room;
  assign not_ready    = !worker_r || stop_r;
  assign commit_ok    = cmd.accept && is_push && in_word_last && !bad && !not_ready;

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    fill_nxt     = fill_r;
    drop_nxt     = drop_r;
    worker_nxt   = worker_r;
    stop_nxt     = stop_r;
    stg_cnt_nxt  = stg_cnt_r;
    stg_ovf_nxt  = stg_ovf_r;
    pop_slot_nxt = pop_slot_r;
    pop_idx_nxt  = pop_idx_r;
    sta          = ST_OK;
    if (cmd.accept) begin
      unique case (in_kind)
        KIND_PUSH: begin
          if (stg_room) begin
            stg_cnt_nxt = stg_cnt_r + CNTW'(1);
          end else begin
            stg_ovf_nxt = 1'b1;
          end
          if (in_word_last) begin
            stg_cnt_nxt = '0;
            stg_ovf_nxt = 1'b0;
            if (bad) begin
              sta = ST_INVALID;
            end else if (not_ready) begin
              sta = ST_NOT_READY;
            end else begin
              tail_nxt = inc_slot(tail_r);
              if (full) begin
                head_nxt = inc_slot(head_r);
                drop_nxt = drop_r + 32'd1;
              end else begin
                fill_nxt = fill_r + FW'(1);
              end
            end
          end
        end
        KIND_POP: begin
          if (fill_r != '0) begin
            head_nxt     = inc_slot(head_r);
            fill_nxt     = fill_r - FW'(1);
            pop_slot_nxt = head_r;
            pop_idx_nxt  = '0;
          end else begin
            sta = ST_NOT_READY;
          end
        end
        KIND_DISCARD: begin
          drop_nxt = drop_r + 32'(fill_r);
          fill_nxt = '0;
          head_nxt = tail_r;
        end
        KIND_START: worker_nxt = 1'b1;
        KIND_STOP:  stop_nxt   = 1'b1;
        default:    sta        = ST_INVALID;
      endcase
    end
    if (cmd.pop_word) begin
      pop_idx_nxt = pop_idx_r + WW'(1);
    end
  end

  // Pop word shaping: words never staged read as zero, the tail of the last word is masked.
  assign nwords       = (11'(m_bytes_r) + 11'd7) >> 3;
  assign pop_last     = (11'(pop_idx_r) == (nwords - 11'd1));
  assign word_present = CNTW'(pop_idx_r) < m_words_r;
  assign pop_payload  = word_present
                        ? (rd_word_r & (pop_last ? byte_mask(m_bytes_r[2:0]) : '1))
                        : '0;

  assign rd_en   = pop_start || cmd.pop_word;
  assign rd_addr = pop_start ? {head_r, WW'(0)} : {pop_slot_r, pop_idx_r + WW'(1)};

  always_ff @(posedge clk) begin
    if (push_wr) begin
      pay_mem[{tail_r, stg_cnt_r[WW-1:0]}] <= in_payload_word;
    end
    if (rd_en) begin
      rd_word_r <= pay_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (commit_ok) begin
      bytes_mem[tail_r] <= in_chunk_bytes;
      time_mem[tail_r]  <= in_timestamp_ns;
      drops_mem[tail_r] <= in_upstream_dropped;
      words_mem[tail_r] <= words_commit;
    end
    if (pop_start) begin
      m_bytes_r <= bytes_mem[head_r];
      m_time_r  <= time_mem[head_r];
      m_drops_r <= drops_mem[head_r];
      m_words_r <= words_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      fill_r    <= '0;
      drop_r    <= '0;
      worker_r  <= 1'b0;
      stop_r    <= 1'b0;
      stg_cnt_r <= '0;
      stg_ovf_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      fill_r    <= fill_nxt;
      drop_r    <= drop_nxt;
      worker_r  <= worker_nxt;
      stop_r    <= stop_nxt;
      stg_cnt_r <= stg_cnt_nxt;
      stg_ovf_r <= stg_ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_slot_r <= pop_slot_nxt;
    pop_idx_r  <= pop_idx_nxt;
    if (cmd.load_single) begin
      out_status_r         <= sta;
      out_payload_r        <= '0;
      out_last_r           <= 1'b1;
      out_bytes_r          <= '0;
      out_timestamp_r      <= '0;
      out_dropped_r        <= '0;
      out_queue_count_r    <= fill_nxt;
      out_chunks_dropped_r <= drop_nxt;
      out_stop_flag_r      <= stop_nxt;
    end else if (cmd.pop_word) begin
      out_status_r         <= ST_OK;
      out_payload_r        <= pop_payload;
      out_last_r           <= pop_last;
      out_bytes_r          <= m_bytes_r;
      out_timestamp_r      <= m_time_r;
      out_dropped_r        <= m_drops_r + drop_r;
      out_queue_count_r    <= fill_r;
      out_chunks_dropped_r <= drop_r;
      out_stop_flag_r      <= stop_r;
    end
  end

  assign st.nonempty  = (fill_r != '0);
  assign st.last_word = pop_last;

  assign out_status         = out_status_r;
  assign out_payload        = out_payload_r;
  assign out_last           = out_last_r;
  assign out_bytes          = out_bytes_r;
  assign out_timestamp      = out_timestamp_r;
  assign out_dropped        = out_dropped_r;
  assign out_queue_count    = out_queue_count_r;
  assign out_chunks_dropped = out_chunks_dropped_r;
  assign out_stop_flag      = out_stop_flag_r;

endmodule

`default_nettype wire

@@ rtl/drop_oldest_chunk_queue.sv @@
// Top level of the drop-oldest chunk queue: controller plus datapath.
//
// A bounded queue of QUEUE_DEPTH audio chunks that drops the oldest chunk when a new one is
// committed into a full queue. Each input word is one command: a push word (staged straight into
// a spare slot of the payload memory and committed on the word marked last), a pop, a discard of
// everything queued, a worker start or a stop request. Every command yields exactly one result
// word, except a pop of a nonempty queue, which streams the head chunk as ceil(bytes/8) result
// words, one per cycle while the output is not stalled, each carrying the chunk's size,
// timestamp and its drop count plus the running total of dropped chunks. Push, discard, start,
// stop and empty pops are taken at one per cycle; the input is held off while a pop streams and
// while the output register is full and stalled. A pop first makes a registered read of the
// head slot, then loads its payload words in turn through the single read port of the payload
// memory; no input word is taken until its final result has been loaded. The payload memory
// holds (QUEUE_DEPTH + 1) slots of CHUNK_WORDS words rounded up to a power of two; there is no
// clearing pass after reset, since only committed chunks are ever read. Words of a chunk that were
// never staged read as zero, and bytes past the chunk size in its last word read as zero.
`default_nettype none

module drop_oldest_chunk_queue #(
  parameter int QUEUE_DEPTH = 8,
  parameter int CHUNK_WORDS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        in_kind,
  input  logic [63:0]                       in_payload_word,
  input  logic                              in_word_last,
  input  logic [docq_pkg::BYTES_W-1:0]      in_chunk_bytes,
  input  logic [63:0]                       in_timestamp_ns,
  input  logic [31:0]                       in_upstream_dropped,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [63:0]                       out_payload,
  output logic                              out_last,
  output logic [docq_pkg::BYTES_W-1:0]      out_bytes,
  output logic [63:0]                       out_timestamp,
  output logic [31:0]                       out_dropped,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]  out_queue_count,
  output logic [31:0]                       out_chunks_dropped,
  output logic                              out_stop_flag
);
  import docq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // The controller owns the handshakes and the pop sequencing.
  docq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  // The datapath holds the slot memories, ring pointers, counters and the result register.
  docq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CHUNK_WORDS (CHUNK_WORDS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .st                  (st),
    .in_kind             (in_kind),
    .in_payload_word     (in_payload_word),
    .in_word_last        (in_word_last),
    .in_chunk_bytes      (in_chunk_bytes),
    .in_timestamp_ns     (in_timestamp_ns),
    .in_upstream_dropped (in_upstream_dropped),
    .out_status          (out_status),
    .out_payload         (out_payload),
    .out_last            (out_last),
    .out_bytes           (out_bytes),
    .out_timestamp       (out_timestamp),
    .out_dropped         (out_dropped),
    .out_queue_count     (out_queue_count),
    .out_chunks_dropped  (out_chunks_dropped),
    .out_stop_flag       (out_stop_flag)
  );

endmodule

`default_nettype wire

@@ rtl/docq_checker.sv @@
// Port-level checker of the drop-oldest chunk queue and its bind to the top level.
`default_nettype none

module docq_checker #(
  parameter int QUEUE_DEPTH = 8,
  parameter int CHUNK_WORDS = 64
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [1:0]                        out_status,
  input logic [63:0]                       out_payload,
  input logic                              out_last,
  input logic [docq_pkg::BYTES_W-1:0]      out_bytes,
  input logic [63:0]                       out_timestamp,
  input logic [$clog2(QUEUE_DEPTH+1)-1:0]  out_queue_count
);
  import docq_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload) && $stable(out_last))
    else $error("stalled result word changed");

  // The queue never reports more chunks than it can hold.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_queue_count <= QUEUE_DEPTH))
    else $error("queue count above depth");

  // A refused command or an empty pop gives one word only.
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_last)
    else $error("non-ok result is not final");

  // A popped chunk streams without gaps and keeps its size and timestamp.
  a_pop_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && (out_bytes == $past(out_bytes)) && (out_timestamp == $past(out_timestamp))
      && (out_bytes <= CHUNK_WORDS * 8))
    else $error("pop stream broken");

  // No input word is taken while a chunk is still being streamed out.
  a_no_accept_mid_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !(in_valid && !in_stall))
    else $error("input accepted during a pop");

endmodule

bind drop_oldest_chunk_queue docq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .CHUNK_WORDS (CHUNK_WORDS)
) u_docq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_payload     (out_payload),
  .out_last        (out_last),
  .out_bytes       (out_bytes),
  .out_timestamp   (out_timestamp),
  .out_queue_count (out_queue_count)
);

`default_nettype wire
